@@ rtl/lzrp_pkg.sv @@
// shared types, constants and code tables of the lz ring prefix decoder
`default_nettype none

package lzrp_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int LEN_W      = 8;
    localparam int DIST_W     = 13;
    localparam int REM_W      = 31;
    localparam int EXTRA_W    = 12;
    localparam int CNT_W      = 4;

    typedef logic [RING_AW-1:0] t_addr;

    // item kinds and requested kinds
    localparam logic [1:0] OP_BIT   = 2'd0;
    localparam logic [1:0] OP_LIT   = 2'd1;
    localparam logic [1:0] OP_PULL  = 2'd2;
    localparam logic [1:0] NEED_FIN = 2'd3;

    // prefix code bases
    localparam logic [LEN_W-1:0]  LEN_BASE_A  = 8'd7;
    localparam logic [LEN_W-1:0]  LEN_BASE_B  = 8'h0b;
    localparam logic [LEN_W-1:0]  LEN_BASE_C  = 8'h13;
    localparam logic [LEN_W-1:0]  LEN_BASE_D  = 8'h23;
    localparam logic [LEN_W-1:0]  LEN_BASE_E  = 8'd99;
    localparam logic [DIST_W-1:0] DIST_BASE_A = 13'd0;
    localparam logic [DIST_W-1:0] DIST_BASE_B = 13'd2;
    localparam logic [DIST_W-1:0] DIST_BASE_C = 13'd6;
    localparam logic [DIST_W-1:0] DIST_BASE_D = 13'd10;
    localparam logic [DIST_W-1:0] DIST_BASE_E = 13'h012;
    localparam logic [DIST_W-1:0] DIST_BASE_F = 13'h022;
    localparam logic [DIST_W-1:0] DIST_BASE_G = 13'h062;
    localparam logic [DIST_W-1:0] DIST_BASE_H = 13'h162;
    localparam logic [DIST_W-1:0] DIST_BASE_I = 13'h562;

    typedef enum logic [4:0] {
        PH_FLAG = 5'd0,
        PH_LIT  = 5'd1,
        PH_COPY = 5'd2,
        PH_L0   = 5'd3,
        PH_L1   = 5'd4,
        PH_L2   = 5'd5,
        PH_L3   = 5'd6,
        PH_L4   = 5'd7,
        PH_L5   = 5'd8,
        PH_L6   = 5'd9,
        PH_L7   = 5'd10,
        PH_L8   = 5'd11,
        PH_LX   = 5'd12,
        PH_D0   = 5'd13,
        PH_D1   = 5'd14,
        PH_D2   = 5'd15,
        PH_D3   = 5'd16,
        PH_D4   = 5'd17,
        PH_D5   = 5'd18,
        PH_D6   = 5'd19,
        PH_D7   = 5'd20,
        PH_DX   = 5'd21
    } t_phase;

    // one decoded item on its way from the decoder to the ring stage
    typedef struct packed {
        logic             is_lit;
        logic             is_copy;
        logic [7:0]       lit;
        t_addr            wr_addr;
        t_addr            rd_addr;
        logic             rd_ok;
        logic             last;
        logic [1:0]       next_need;
        logic             wrong;
    } t_item;

    function automatic logic [CNT_W-1:0] len_extra_width(input logic [LEN_W-1:0] base);
        logic [CNT_W-1:0] w;
        unique case (base)
            LEN_BASE_A: w = 4'd2;
            LEN_BASE_B: w = 4'd3;
            LEN_BASE_C: w = 4'd4;
            LEN_BASE_D: w = 4'd6;
            default:    w = 4'd7;
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] dist_extra_width(input logic [DIST_W-1:0] base);
        logic [CNT_W-1:0] w;
        unique case (base)
            DIST_BASE_A: w = 4'd1;
            DIST_BASE_B: w = 4'd2;
            DIST_BASE_C: w = 4'd2;
            DIST_BASE_D: w = 4'd3;
            DIST_BASE_E: w = 4'd4;
            DIST_BASE_F: w = 4'd6;
            DIST_BASE_G: w = 4'd8;
            DIST_BASE_H: w = 4'd10;
            default:     w = 4'd12;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] need_of(input t_phase ph, input logic [REM_W-1:0] rem);
        logic [1:0] n;
        if (ph == PH_LIT) begin
            n = OP_LIT;
        end else if (ph == PH_COPY) begin
            n = OP_PULL;
        end else if (ph == PH_FLAG && rem == '0) begin
            n = NEED_FIN;
        end else begin
            n = OP_BIT;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lzrp_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module lzrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/lzrp_ctrl.sv @@
// decode state machine: flag, prefix code and extra bits, pointers and counts
`default_nettype none

module lzrp_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [lzrp_pkg::REM_W-1:0]   i_cfg_wr_data,
    input  wire logic                         i_accept,
    input  wire logic [1:0]                   i_operation,
    input  wire logic                         i_code_bit,
    input  wire logic [7:0]                   i_literal,
    output lzrp_pkg::t_item                   o_item
);

    localparam lzrp_pkg::t_addr              WP_LAST = lzrp_pkg::RING_AW'(lzrp_pkg::RING_DEPTH - 1);

    lzrp_pkg::t_phase                r_phase, n_phase;
    lzrp_pkg::t_addr                 r_wp, n_wp;
    logic                            r_full, n_full;
    logic [lzrp_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [lzrp_pkg::EXTRA_W-1:0]    r_ev, n_ev;
    logic [lzrp_pkg::CNT_W-1:0]      r_ec, n_ec;
    logic [lzrp_pkg::LEN_W-1:0]      r_ml, n_ml;
    logic [lzrp_pkg::DIST_W-1:0]     r_md, n_md;

    logic [1:0]                      need;
    logic                            wrong;
    logic                            take;
    logic [lzrp_pkg::EXTRA_W-1:0]    ev_acc;
    logic [lzrp_pkg::CNT_W-1:0]      ec_inc;
    lzrp_pkg::t_addr                 src;
    logic [lzrp_pkg::LEN_W-1:0]      ml_dec;
    logic [lzrp_pkg::DIST_W-1:0]     md_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lzrp_pkg::PH_FLAG;
            r_wp    <= '0;
            r_full  <= 1'b0;
            r_rem   <= '0;
            r_ev    <= '0;
            r_ec    <= '0;
            r_ml    <= '0;
            r_md    <= '0;
        end else begin
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_full  <= n_full;
            r_rem   <= n_rem;
            r_ev    <= n_ev;
            r_ec    <= n_ec;
            r_ml    <= n_ml;
            r_md    <= n_md;
        end
    end

    // copy source: write pointer minus distance minus one, modulo the ring depth
    always_comb begin
        src = r_wp - r_md[lzrp_pkg::RING_AW-1:0] - 1'b1;
    end

    always_comb begin
        n_phase = r_phase;
        n_wp    = r_wp;
        n_full  = r_full;
        n_rem   = r_rem;
        n_ev    = r_ev;
        n_ec    = r_ec;
        n_ml    = r_ml;
        n_md    = r_md;

        need    = lzrp_pkg::need_of(r_phase, r_rem);
        wrong   = (need == lzrp_pkg::NEED_FIN) || (i_operation != need);
        take    = i_accept && !wrong;
        ev_acc  = r_ev | (lzrp_pkg::EXTRA_W'(i_code_bit) << r_ec);
        ec_inc  = r_ec + 1'b1;
        ml_dec  = r_ml - 1'b1;
        md_done = r_md + {1'b0, ev_acc};

        o_item.is_lit  = 1'b0;
        o_item.is_copy = 1'b0;
        o_item.lit     = i_literal;
        o_item.wr_addr = r_wp;
        o_item.rd_addr = src;
        // entries beyond the fill mark were never written and read as zero
        o_item.rd_ok   = r_full || (src < r_wp);
        o_item.wrong   = wrong;

        if (take) begin
            unique case (i_operation)
                lzrp_pkg::OP_BIT: begin
                    unique case (r_phase)
                        lzrp_pkg::PH_FLAG: begin
                            n_phase = i_code_bit ? lzrp_pkg::PH_L0 : lzrp_pkg::PH_LIT;
                        end
                        lzrp_pkg::PH_L0: begin
                            n_phase = i_code_bit ? lzrp_pkg::PH_L2 : lzrp_pkg::PH_L1;
                        end
                        lzrp_pkg::PH_L1: begin
                            n_ml    = i_code_bit ? 8'd4 : 8'd2;
                            n_phase = lzrp_pkg::PH_D0;
                        end
                        lzrp_pkg::PH_L2: begin
                            n_phase = i_code_bit ? lzrp_pkg::PH_L5 : lzrp_pkg::PH_L3;
                        end
                        lzrp_pkg::PH_L3: begin
                            if (i_code_bit) begin
                                n_ml    = lzrp_pkg::LEN_BASE_A;
                                n_ev    = '0;
                                n_ec    = '0;
                                n_phase = lzrp_pkg::PH_LX;
                            end else begin
                                n_phase = lzrp_pkg::PH_L4;
                            end
                        end
                        lzrp_pkg::PH_L4: begin
                            if (i_code_bit) begin
                                n_ml    = lzrp_pkg::LEN_BASE_B;
                                n_ev    = '0;
                                n_ec    = '0;
                                n_phase = lzrp_pkg::PH_LX;
                            end else begin
                                n_ml    = 8'd3;
                                n_phase = lzrp_pkg::PH_D0;
                            end
                        end
                        lzrp_pkg::PH_L5: begin
                            n_phase = i_code_bit ? lzrp_pkg::PH_L7 : lzrp_pkg::PH_L6;
                        end
                        lzrp_pkg::PH_L6: begin
                            if (i_code_bit) begin
                                n_ml    = lzrp_pkg::LEN_BASE_D;
                                n_ev    = '0;
                                n_ec    = '0;
                                n_phase = lzrp_pkg::PH_LX;
                            end else begin
                                n_ml    = 8'd5;
                                n_phase = lzrp_pkg::PH_D0;
                            end
                        end
                        lzrp_pkg::PH_L7: begin
                            if (i_code_bit) begin
                                n_phase = lzrp_pkg::PH_L8;
                            end else begin
                                n_ml    = 8'd6;
                                n_phase = lzrp_pkg::PH_D0;
                            end
                        end
                        lzrp_pkg::PH_L8: begin
                            n_ml    = i_code_bit ? lzrp_pkg::LEN_BASE_E : lzrp_pkg::LEN_BASE_C;
                            n_ev    = '0;
                            n_ec    = '0;
                            n_phase = lzrp_pkg::PH_LX;
                        end
                        lzrp_pkg::PH_LX: begin
                            n_ev = ev_acc;
                            n_ec = ec_inc;
                            if (ec_inc >= lzrp_pkg::len_extra_width(r_ml)) begin
                                n_ml    = r_ml + ev_acc[lzrp_pkg::LEN_W-1:0];
                                n_phase = lzrp_pkg::PH_D0;
                            end
                        end
                        lzrp_pkg::PH_D0: begin
                            n_phase = i_code_bit ? lzrp_pkg::PH_D1 : lzrp_pkg::PH_D2;
                        end
                        lzrp_pkg::PH_D1: begin
                            n_md    = i_code_bit ? lzrp_pkg::DIST_BASE_H : lzrp_pkg::DIST_BASE_I;
                            n_ev    = '0;
                            n_ec    = '0;
                            n_phase = lzrp_pkg::PH_DX;
                        end
                        lzrp_pkg::PH_D2: begin
                            n_phase = i_code_bit ? lzrp_pkg::PH_D3 : lzrp_pkg::PH_D4;
                        end
                        lzrp_pkg::PH_D3: begin
                            n_md    = i_code_bit ? lzrp_pkg::DIST_BASE_G : lzrp_pkg::DIST_BASE_F;
                            n_ev    = '0;
                            n_ec    = '0;
                            n_phase = lzrp_pkg::PH_DX;
                        end
                        lzrp_pkg::PH_D4: begin
                            n_phase = i_code_bit ? lzrp_pkg::PH_D6 : lzrp_pkg::PH_D5;
                        end
                        lzrp_pkg::PH_D5: begin
                            n_md    = i_code_bit ? lzrp_pkg::DIST_BASE_B : lzrp_pkg::DIST_BASE_D;
                            n_ev    = '0;
                            n_ec    = '0;
                            n_phase = lzrp_pkg::PH_DX;
                        end
                        lzrp_pkg::PH_D6: begin
                            if (i_code_bit) begin
                                n_phase = lzrp_pkg::PH_D7;
                            end else begin
                                n_md    = lzrp_pkg::DIST_BASE_C;
                                n_ev    = '0;
                                n_ec    = '0;
                                n_phase = lzrp_pkg::PH_DX;
                            end
                        end
                        lzrp_pkg::PH_D7: begin
                            n_md    = i_code_bit ? lzrp_pkg::DIST_BASE_A : lzrp_pkg::DIST_BASE_E;
                            n_ev    = '0;
                            n_ec    = '0;
                            n_phase = lzrp_pkg::PH_DX;
                        end
                        lzrp_pkg::PH_DX: begin
                            n_ev = ev_acc;
                            n_ec = ec_inc;
                            if (ec_inc >= lzrp_pkg::dist_extra_width(r_md)) begin
                                n_md = md_done;
                                // clamp the match to what is left of the stream
                                if (r_rem <= lzrp_pkg::REM_W'(r_ml)) begin
                                    n_ml = r_rem[lzrp_pkg::LEN_W-1:0];
                                end
                                n_phase = lzrp_pkg::PH_COPY;
                            end
                        end
                        default: begin
                            n_phase = lzrp_pkg::PH_FLAG;
                        end
                    endcase
                end
                lzrp_pkg::OP_LIT: begin
                    o_item.is_lit = 1'b1;
                    n_wp    = (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
                    n_full  = r_full || (r_wp == WP_LAST);
                    n_rem   = r_rem - 1'b1;
                    n_phase = lzrp_pkg::PH_FLAG;
                end
                lzrp_pkg::OP_PULL: begin
                    o_item.is_copy = 1'b1;
                    n_wp    = (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
                    n_full  = r_full || (r_wp == WP_LAST);
                    n_rem   = r_rem - 1'b1;
                    n_ml    = ml_dec;
                    if (ml_dec == '0 || n_rem == '0) begin
                        n_phase = lzrp_pkg::PH_FLAG;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        // a new stream length restarts decoding; ring contents are kept
        if (i_cfg_wr_en) begin
            n_rem   = i_cfg_wr_data;
            n_phase = lzrp_pkg::PH_FLAG;
            n_ev    = '0;
            n_ec    = '0;
            n_ml    = '0;
            n_md    = '0;
        end

        o_item.last      = (o_item.is_lit || o_item.is_copy) && (n_rem == '0);
        o_item.next_need = lzrp_pkg::need_of(n_phase, n_rem);
    end

endmodule

`default_nettype wire

@@ rtl/lz_ring_prefix_decoder_unit.sv @@
// top level: decoder, history ring memory, ring read stage and output register
`default_nettype none

// LZSS-style stream decoder with a 1024-byte history ring. Each accepted item is a
// code bit, a literal byte or a pull of the next copied byte, and gives exactly one
// result that also tells which kind of item is wanted next (an item of the wrong kind
// is flagged and changes nothing). One item is accepted per clock cycle while the
// receiver keeps taking results; the decode state machine works in the accepting
// cycle, the accepting edge loads the ring stage and launches the ring memory read,
// and the ring stage then forms the byte and loads the output register. With the
// receiver stalled, the ring stage and the output register hold two items and the
// input then waits. Copied bytes come from the single-port-read ring memory, and a
// pull that reads the byte written by the item just ahead of it is served by
// forwarding, so pulls also run at one per cycle while the receiver keeps up. No
// clearing pass is needed after reset: a fill mark tracks which ring entries were
// written, and the rest read as zero. Writing total_length restarts decoding of a
// new stream and keeps the ring.
module lz_ring_prefix_decoder_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [lzrp_pkg::REM_W-1:0] i_cfg_wr_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_operation,
    input  wire logic                       i_code_bit,
    input  wire logic [7:0]                 i_literal,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_byte_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_byte,
    output logic [1:0]                      o_next_need,
    output logic                            o_wrong_item
);

    lzrp_pkg::t_item   s0_item;
    logic              accept;
    logic              s1_adv;
    logic              s1_writes;
    logic [7:0]        s1_byte;
    logic [7:0]        ram_q;
    logic              fwd;

    logic              r_s1_v;
    lzrp_pkg::t_item   r_s1;
    logic              r_s1_fwd;
    logic [7:0]        r_s1_fwd_byte;

    logic              r_o_v;
    logic              r_o_byte_valid;
    logic [7:0]        r_o_byte;
    logic              r_o_last;
    logic [1:0]        r_o_need;
    logic              r_o_wrong;

    assign s1_adv     = r_s1_v && (!r_o_v || i_out_ready);
    assign o_in_ready = !r_s1_v || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    lzrp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_code_bit   (i_code_bit),
        .i_literal    (i_literal),
        .o_item       (s0_item)
    );

    assign s1_writes = r_s1.is_lit || r_s1.is_copy;

    always_comb begin
        if (r_s1.is_lit) begin
            s1_byte = r_s1.lit;
        end else if (r_s1.is_copy && r_s1.rd_ok) begin
            s1_byte = r_s1_fwd ? r_s1_fwd_byte : ram_q;
        end else begin
            s1_byte = '0;
        end
    end

    // the ring entry being written this cycle is the one a new pull reads
    assign fwd = s1_adv && s1_writes && s0_item.is_copy &&
                 (r_s1.wr_addr == s0_item.rd_addr);

    lzrp_ram #(
        .WIDTH(8),
        .DEPTH(lzrp_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (s1_adv && s1_writes),
        .i_waddr(r_s1.wr_addr),
        .i_wdata(s1_byte),
        .i_re   (accept && s0_item.is_copy),
        .i_raddr(s0_item.rd_addr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_o_v <= 1'b1;
            end else if (i_out_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1          <= s0_item;
            r_s1_fwd      <= fwd;
            r_s1_fwd_byte <= s1_byte;
        end
        if (s1_adv) begin
            r_o_byte_valid <= s1_writes;
            r_o_byte       <= s1_byte;
            r_o_last       <= r_s1.last;
            r_o_need       <= r_s1.next_need;
            r_o_wrong      <= r_s1.wrong;
        end
    end

    assign o_out_valid  = r_o_v;
    assign o_byte_valid = r_o_byte_valid;
    assign o_out_byte   = r_o_byte;
    assign o_last_byte  = r_o_last;
    assign o_next_need  = r_o_need;
    assign o_wrong_item = r_o_wrong;

    a_wrong_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1.wrong |-> !r_s1.is_lit && !r_s1.is_copy)
        else $error("wrong item carries a byte");

    a_last_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_next_need == lzrp_pkg::NEED_FIN)
        else $error("last byte without finished stream");

    a_fwd_copy_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1_fwd |-> r_s1.is_copy && r_s1.rd_ok)
        else $error("forwarded byte outside a valid copy");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_adv |=> r_s1_v && $stable(r_s1))
        else $error("stalled ring stage item changed");

endmodule

`default_nettype wire

@@ bench/tb_lz_ring_prefix_decoder_unit.sv @@
// self-checking testbench for the lz ring prefix decoder with a scoreboard class
`timescale 1ns / 1ps

module tb_lz_ring_prefix_decoder_unit;

    localparam logic [1:0] OP_BAD      = 2'd3;  // operation code with no meaning
    localparam int         QUIET_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic       bv;
        logic [7:0] data;
        logic       last;
        logic [1:0] need;
        logic       wrong;
    } t_result;

    // predicts every result of the decoder and keeps the ones still to arrive
    class lz_decode_board;
        logic [7:0]       ring [lzrp_pkg::RING_DEPTH];
        lzrp_pkg::t_addr  wptr;
        logic [lzrp_pkg::REM_W-1:0] remaining;
        lzrp_pkg::t_phase phase;
        logic [lzrp_pkg::EXTRA_W-1:0] xval;
        logic [lzrp_pkg::CNT_W-1:0] xcnt;
        logic [lzrp_pkg::LEN_W-1:0] mlen;
        logic [lzrp_pkg::DIST_W-1:0] mdist;
        t_result          awaited_results[$];
        int               errors;

        function new();
            foreach (ring[i]) ring[i] = 8'h00;
            wptr = '0;
            remaining = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase = lzrp_pkg::PH_FLAG;
            xval = '0;
            xcnt = '0;
            mlen = '0;
            mdist = '0;
        endfunction

        function void load_length(input logic [lzrp_pkg::REM_W-1:0] v);
            remaining = v;
            restart();
        endfunction

        function logic [1:0] wanted();
            logic [1:0] n;
            if (phase == lzrp_pkg::PH_LIT) begin
                n = lzrp_pkg::OP_LIT;
            end else if (phase == lzrp_pkg::PH_COPY) begin
                n = lzrp_pkg::OP_PULL;
            end else if (phase == lzrp_pkg::PH_FLAG && remaining == '0) begin
                n = lzrp_pkg::NEED_FIN;
            end else begin
                n = lzrp_pkg::OP_BIT;
            end
            return n;
        endfunction

        function logic [lzrp_pkg::CNT_W-1:0] len_bits(input logic [lzrp_pkg::LEN_W-1:0] base);
            if (base == lzrp_pkg::LEN_BASE_A) return 4'd2;
            if (base == lzrp_pkg::LEN_BASE_B) return 4'd3;
            if (base == lzrp_pkg::LEN_BASE_C) return 4'd4;
            if (base == lzrp_pkg::LEN_BASE_D) return 4'd6;
            return 4'd7;
        endfunction

        function logic [lzrp_pkg::CNT_W-1:0] dist_bits(
                input logic [lzrp_pkg::DIST_W-1:0] base);
            if (base == lzrp_pkg::DIST_BASE_A) return 4'd1;
            if (base == lzrp_pkg::DIST_BASE_B || base == lzrp_pkg::DIST_BASE_C) return 4'd2;
            if (base == lzrp_pkg::DIST_BASE_D) return 4'd3;
            if (base == lzrp_pkg::DIST_BASE_E) return 4'd4;
            if (base == lzrp_pkg::DIST_BASE_F) return 4'd6;
            if (base == lzrp_pkg::DIST_BASE_G) return 4'd8;
            if (base == lzrp_pkg::DIST_BASE_H) return 4'd10;
            return 4'd12;
        endfunction

        function void end_length(input logic [lzrp_pkg::LEN_W-1:0] v);
            mlen = v;
            phase = lzrp_pkg::PH_D0;
        endfunction

        function void open_len_extra(input logic [lzrp_pkg::LEN_W-1:0] base);
            mlen = base;
            xval = '0;
            xcnt = '0;
            phase = lzrp_pkg::PH_LX;
        endfunction

        function void end_distance(input logic [lzrp_pkg::DIST_W-1:0] v);
            mdist = v;
            // a match never runs past the end of the stream
            if (remaining <= lzrp_pkg::REM_W'(mlen)) mlen = lzrp_pkg::LEN_W'(remaining);
            phase = lzrp_pkg::PH_COPY;
        endfunction

        function void open_dist_extra(input logic [lzrp_pkg::DIST_W-1:0] base);
            mdist = base;
            xval = '0;
            xcnt = '0;
            phase = lzrp_pkg::PH_DX;
        endfunction

        function void shift_bit(input logic cbit);
            case (phase)
                lzrp_pkg::PH_FLAG: phase = cbit ? lzrp_pkg::PH_L0 : lzrp_pkg::PH_LIT;
                lzrp_pkg::PH_L0:   phase = cbit ? lzrp_pkg::PH_L2 : lzrp_pkg::PH_L1;
                lzrp_pkg::PH_L1:   end_length(cbit ? 8'd4 : 8'd2);
                lzrp_pkg::PH_L2:   phase = cbit ? lzrp_pkg::PH_L5 : lzrp_pkg::PH_L3;
                lzrp_pkg::PH_L3: begin
                    if (cbit) open_len_extra(lzrp_pkg::LEN_BASE_A);
                    else phase = lzrp_pkg::PH_L4;
                end
                lzrp_pkg::PH_L4: begin
                    if (cbit) open_len_extra(lzrp_pkg::LEN_BASE_B);
                    else end_length(8'd3);
                end
                lzrp_pkg::PH_L5:   phase = cbit ? lzrp_pkg::PH_L7 : lzrp_pkg::PH_L6;
                lzrp_pkg::PH_L6: begin
                    if (cbit) open_len_extra(lzrp_pkg::LEN_BASE_D);
                    else end_length(8'd5);
                end
                lzrp_pkg::PH_L7: begin
                    if (cbit) phase = lzrp_pkg::PH_L8;
                    else end_length(8'd6);
                end
                lzrp_pkg::PH_L8:
                    open_len_extra(cbit ? lzrp_pkg::LEN_BASE_E : lzrp_pkg::LEN_BASE_C);
                lzrp_pkg::PH_LX: begin
                    // extra bits come in lsb first
                    xval = xval | (lzrp_pkg::EXTRA_W'(cbit) << xcnt);
                    xcnt = xcnt + 1'b1;
                    if (xcnt >= len_bits(mlen)) end_length(lzrp_pkg::LEN_W'(mlen + xval));
                end
                lzrp_pkg::PH_D0:   phase = cbit ? lzrp_pkg::PH_D1 : lzrp_pkg::PH_D2;
                lzrp_pkg::PH_D1:
                    open_dist_extra(cbit ? lzrp_pkg::DIST_BASE_H : lzrp_pkg::DIST_BASE_I);
                lzrp_pkg::PH_D2:   phase = cbit ? lzrp_pkg::PH_D3 : lzrp_pkg::PH_D4;
                lzrp_pkg::PH_D3:
                    open_dist_extra(cbit ? lzrp_pkg::DIST_BASE_G : lzrp_pkg::DIST_BASE_F);
                lzrp_pkg::PH_D4:   phase = cbit ? lzrp_pkg::PH_D6 : lzrp_pkg::PH_D5;
                lzrp_pkg::PH_D5:
                    open_dist_extra(cbit ? lzrp_pkg::DIST_BASE_B : lzrp_pkg::DIST_BASE_D);
                lzrp_pkg::PH_D6: begin
                    if (cbit) phase = lzrp_pkg::PH_D7;
                    else open_dist_extra(lzrp_pkg::DIST_BASE_C);
                end
                lzrp_pkg::PH_D7:
                    open_dist_extra(cbit ? lzrp_pkg::DIST_BASE_A : lzrp_pkg::DIST_BASE_E);
                lzrp_pkg::PH_DX: begin
                    xval = xval | (lzrp_pkg::EXTRA_W'(cbit) << xcnt);
                    xcnt = xcnt + 1'b1;
                    if (xcnt >= dist_bits(mdist)) begin
                        end_distance(lzrp_pkg::DIST_W'(mdist + xval));
                    end
                end
                default: phase = lzrp_pkg::PH_FLAG;
            endcase
        endfunction

        function void store_byte(input logic [7:0] v);
            ring[wptr] = v;
            wptr = wptr + 1'b1;
            remaining = remaining - 1'b1;
        endfunction

        // works out the result of one accepted item, returns 1 when it is ignored
        function bit decode_item(input logic [1:0] op, input logic cbit,
                                 input logic [7:0] lit);
            t_result r;
            logic [1:0] want;
            lzrp_pkg::t_addr src;
            r = '0;
            want = wanted();
            if (want == lzrp_pkg::NEED_FIN || op != want) begin
                r.wrong = 1'b1;
            end else if (op == lzrp_pkg::OP_BIT) begin
                shift_bit(cbit);
            end else if (op == lzrp_pkg::OP_LIT) begin
                r.bv = 1'b1;
                r.data = lit;
                store_byte(lit);
                phase = lzrp_pkg::PH_FLAG;
                r.last = (remaining == '0);
            end else begin
                // far distances wrap around the ring
                src = wptr - mdist[lzrp_pkg::RING_AW-1:0] - 1'b1;
                r.bv = 1'b1;
                r.data = ring[src];
                store_byte(r.data);
                mlen = mlen - 1'b1;
                if (mlen == '0 || remaining == '0) phase = lzrp_pkg::PH_FLAG;
                r.last = (remaining == '0);
            end
            r.need = wanted();
            awaited_results.push_back(r);
            return r.wrong;
        endfunction

        task report(input string what, input int seen, input int want);
            $display("mismatch %s: got %0h, expected %0h at %0t", what, seen, want, $time);
            errors++;
        endtask

        task match_result(input t_result got);
            t_result w;
            if (awaited_results.size() == 0) begin
                report("unexpected result", int'(got), 0);
            end else begin
                w = awaited_results.pop_front();
                if (got.bv != w.bv) report("byte_valid", int'(got.bv), int'(w.bv));
                if (got.data != w.data) report("out_byte", int'(got.data), int'(w.data));
                if (got.last != w.last) report("last_byte", int'(got.last), int'(w.last));
                if (got.need != w.need) report("next_need", int'(got.need), int'(w.need));
                if (got.wrong != w.wrong) begin
                    report("wrong_item", int'(got.wrong), int'(w.wrong));
                end
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [lzrp_pkg::REM_W-1:0] i_cfg_wr_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_operation = lzrp_pkg::OP_BIT;
    logic              i_code_bit = 1'b0;
    logic [7:0]        i_literal = 8'h00;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_byte_valid;
    logic [7:0]        o_out_byte;
    logic              o_last_byte;
    logic [1:0]        o_next_need;
    logic              o_wrong_item;

    lz_decode_board board = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int random_items = 0;

    lz_ring_prefix_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_code_bit    (i_code_bit),
        .i_literal     (i_literal),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_valid  (o_byte_valid),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte),
        .o_next_need   (o_next_need),
        .o_wrong_item  (o_wrong_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic send_item(input logic [1:0] op, input logic cbit, input logic [7:0] lit,
                             output bit ignored);
        if (!calm) begin
            while ($urandom_range(99) < 20) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_code_bit <= cbit;
        i_literal <= lit;
        do @(posedge i_clk); while (!o_in_ready);
        ignored = board.decode_item(op, cbit, lit);
    endtask

    task automatic send(input logic [1:0] op, input logic cbit, input logic [7:0] lit);
        bit ignored;
        send_item(op, cbit, lit, ignored);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [lzrp_pkg::REM_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        board.load_length(v);
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed items with random content, some noise of any kind
    task automatic stream_items(input int count);
        int taken;
        bit ignored;
        logic [1:0] op;
        logic [1:0] want;
        taken = 0;
        while (taken < count) begin
            want = board.wanted();
            if (want == lzrp_pkg::NEED_FIN) begin
                repeat (2) send(2'($urandom_range(3)), 1'($urandom), 8'($urandom));
                taken = count;
            end else begin
                op = ($urandom_range(99) < 8) ? 2'($urandom_range(3)) : want;
                send_item(op, 1'($urandom), 8'($urandom), ignored);
                if (!ignored) begin
                    taken++;
                    random_items++;
                end
            end
        end
    endtask

    // result side: checks at the edge, then picks ready for the next cycle
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                board.match_result({o_byte_valid, o_out_byte, o_last_byte,
                                    o_next_need, o_wrong_item});
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int k;
        logic [lzrp_pkg::REM_W-1:0] len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stream after reset: everything is refused
        send(lzrp_pkg::OP_BIT, 1'b1, 8'h00);
        send(OP_BAD, 1'b0, 8'hff);
        drain();
        write_length(31'd3);
        send(lzrp_pkg::OP_LIT, 1'b0, 8'hff);
        send(lzrp_pkg::OP_BIT, 1'b0, 8'h00);
        send(lzrp_pkg::OP_LIT, 1'b1, 8'hff);
        send(lzrp_pkg::OP_BIT, 1'b0, 8'haa);
        send(lzrp_pkg::OP_LIT, 1'b0, 8'h00);
        // match of length two whose distance extra bits are left unfinished; every pull is refused
        send(lzrp_pkg::OP_BIT, 1'b1, 8'h00);
        send(lzrp_pkg::OP_BIT, 1'b0, 8'h00);
        send(lzrp_pkg::OP_BIT, 1'b0, 8'h00);
        send(lzrp_pkg::OP_PULL, 1'b1, 8'h55);
        send(lzrp_pkg::OP_BIT, 1'b0, 8'h00);
        send(lzrp_pkg::OP_BIT, 1'b1, 8'h00);
        send(lzrp_pkg::OP_BIT, 1'b1, 8'h00);
        send(lzrp_pkg::OP_BIT, 1'b1, 8'h00);
        send(lzrp_pkg::OP_BIT, 1'b0, 8'hff);
        send(lzrp_pkg::OP_PULL, 1'b0, 8'h00);
        send(lzrp_pkg::OP_PULL, 1'b1, 8'hff);
        drain();

        k = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (k % 6)
                0:       len = {lzrp_pkg::REM_W{1'b1}};
                1:       len = lzrp_pkg::REM_W'($urandom_range(40, 1));
                2:       len = lzrp_pkg::REM_W'($urandom_range(600, 100));
                3:       len = lzrp_pkg::REM_W'($urandom);
                4:       len = 31'd1;
                default: len = '0;
            endcase
            write_length(len);
            calm = (k == 2);
            if (k == 0) hold_req = 1'b1;
            stream_items(calm ? 300 : int'($urandom_range(250, 80)));
            drain();
            calm = 1'b0;
            k++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (board.awaited_results.size() != 0) begin
            board.report("results never seen", board.awaited_results.size(), 0);
        end
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
